@@ sv/stream_distinct_filter_top_macros.svh @@
// Assertion macros for the stream distinct filter.
// Used by stream_distinct_filter_top; no other dependencies.
`ifndef STREAM_DISTINCT_FILTER_TOP_MACROS_SVH
`define STREAM_DISTINCT_FILTER_TOP_MACROS_SVH
// check that a condition implies a consequence in the same cycle
`define SDF_ASSERT_IMPL(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);
// check that a condition implies a consequence in the next cycle
`define SDF_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/sdf_pkg.sv @@
// Shared types, constants and float compare for the stream distinct filter.
// No dependencies.
package sdf_pkg;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned ValueW = 32;
  localparam int unsigned DistW = 7;
  localparam int unsigned RemW = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // token travelling down the cell chain
  typedef struct packed {
    logic              active;
    logic              found;
    logic [ValueW-1:0] value;
  } probe_t;

  function automatic logic is_nan(input logic [ValueW-1:0] b);
    return b[30:0] > 31'h7F800000;
  endfunction

  function automatic logic float_eq(input logic [ValueW-1:0] a,
                                    input logic [ValueW-1:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] | b[30:0]) == 31'd0) return 1'b1;
    return a == b;
  endfunction
endpackage

@@ sv/sdf_stream_if.sv @@
// Valid/ready stream interface carrying a generic payload.
// No dependencies.
interface sdf_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/stream_distinct_filter_top.sv @@
// Stream distinct filter: each value ripples through a chain of STORE_DEPTH
// compare cells, one cell a cycle, and the result is offered once the probe
// leaves the last cell; one item is in flight at a time, so a new item is
// accepted only after the previous result has been taken. A new value is
// written into the first empty cell.
// Depends on sdf_pkg, sdf_stream_if, sdf_cell and the macros header.
`include "stream_distinct_filter_top_macros.svh"
module stream_distinct_filter_top #(
  parameter int unsigned STORE_DEPTH = sdf_pkg::StoreDepth
) (
  input logic clk,
  input logic rst,
  sdf_stream_if.sink   in_s,
  sdf_stream_if.source out_s
);
  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);

  sdf_pkg::state_t state, state_next;
  sdf_pkg::probe_t chain [STORE_DEPTH+1];
  logic [STORE_DEPTH-1:0] wr;
  logic [CntW-1:0] stored;
  logic [sdf_pkg::RemW-1:0] dropped;
  logic [sdf_pkg::ValueW-1:0] value;
  logic last;
  logic clear;
  logic fin;
  logic new_v, ovf;

  assign in_s.ready = (state == sdf_pkg::ST_IDLE);
  assign fin = (state == sdf_pkg::ST_SCAN) && chain[STORE_DEPTH].active;
  assign new_v = fin && !chain[STORE_DEPTH].found && (stored < CntW'(STORE_DEPTH));
  assign ovf = fin && !chain[STORE_DEPTH].found && (stored >= CntW'(STORE_DEPTH));
  assign clear = out_s.valid && out_s.ready && last;

  assign chain[0].active = in_s.valid && in_s.ready;
  assign chain[0].found = 1'b0;
  assign chain[0].value = in_s.valid && in_s.ready ? in_s.data[32:1] : value;

  genvar g;
  generate
    for (g = 0; g < STORE_DEPTH; g++) begin : g_cell
      sdf_pkg::probe_t pin;
      always_comb begin
        pin = chain[g];
        if (wr[g]) pin.value = value;
      end
      assign wr[g] = new_v && (stored == CntW'(g));
      sdf_cell u_cell (
        .clk(clk), .rst(rst), .clear(clear), .write(wr[g]),
        .probe_in(pin), .probe_out(chain[g+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sdf_pkg::ST_IDLE: if (in_s.valid) state_next = sdf_pkg::ST_SCAN;
      sdf_pkg::ST_SCAN: if (fin) state_next = sdf_pkg::ST_DONE;
      sdf_pkg::ST_DONE: if (out_s.ready) state_next = sdf_pkg::ST_IDLE;
      default: state_next = sdf_pkg::ST_IDLE;
    endcase
  end

  logic o_new, o_ovf;
  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
      dropped <= '0;
    end else begin
      if (clear) begin
        stored <= '0;
        dropped <= '0;
      end else if (new_v) begin
        stored <= stored + CntW'(1);
      end else if (fin && chain[STORE_DEPTH].found && dropped != '1) begin
        dropped <= dropped + sdf_pkg::RemW'(1);
      end
    end
    if (in_s.valid && in_s.ready) begin
      value <= in_s.data[32:1];
      last <= in_s.data[0];
    end
    if (fin) begin
      o_new <= new_v;
      o_ovf <= ovf;
    end
  end

  assign out_s.valid = (state == sdf_pkg::ST_DONE);
  assign out_s.data = {value, o_new, sdf_pkg::DistW'(stored), dropped, o_ovf, last};

  `SDF_ASSERT_IMPL(a_new_ovf, out_s.valid, !(o_new && o_ovf), "new and overflow both set")
  `SDF_ASSERT_IMPL(a_one_wr, 1'b1, $onehot0(wr), "more than one cell written")
  `SDF_ASSERT_NEXT(a_clear, clear, stored == '0, "count not cleared after last")
  `SDF_ASSERT_IMPL(a_cap, 1'b1, stored <= CntW'(STORE_DEPTH), "count past depth")
endmodule

@@ sv/sdf_cell.sv @@
// One store cell: holds a value and its valid bit, compares the passing probe.
// Depends on sdf_pkg.
module sdf_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      write,
  input  sdf_pkg::probe_t           probe_in,
  output sdf_pkg::probe_t           probe_out
);
  logic [sdf_pkg::ValueW-1:0] value;
  logic                       full;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      full <= 1'b0;
    end else if (write) begin
      full <= 1'b1;
    end
    if (write) begin
      value <= probe_in.value;
    end
  end

  // hand the probe on, marking a match against a filled cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.active <= 1'b0;
    end else begin
      probe_out.active <= probe_in.active;
    end
    probe_out.value <= probe_in.value;
    probe_out.found <= probe_in.found |
                       (full & sdf_pkg::float_eq(value, probe_in.value));
  end
endmodule

@@ dv/sdf_tb_pkg.sv @@
// Transaction types for the stream distinct filter testbench.
// Depends on sdf_pkg for the field widths.
package sdf_tb_pkg;
  typedef struct packed {
    logic [sdf_pkg::ValueW-1:0] value_bits;
    logic                       last_item;
  } in_item_t;

  typedef struct packed {
    logic [sdf_pkg::ValueW-1:0] value_echo;
    logic                       is_new;
    logic [sdf_pkg::DistW-1:0]  distinct_count;
    logic [sdf_pkg::RemW-1:0]   removed_count;
    logic                       overflow;
    logic                       last_out;
  } out_item_t;
endpackage

@@ dv/distinct_checker.sv @@
// Checker for the stream distinct filter: predicts each result from the
// accepted inputs and compares it with the output stream.
// Depends on sdf_pkg and sdf_tb_pkg.
module distinct_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  sdf_tb_pkg::in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  sdf_tb_pkg::out_item_t out_data,
  output int   fail_count,
  output int   pending
);
  logic [sdf_pkg::ValueW-1:0] seen_vals[sdf_pkg::StoreDepth];
  int unsigned                seen_cnt;
  int unsigned                dup_cnt;
  sdf_tb_pkg::out_item_t      expected_q[$];

  function automatic bit nan_pattern(logic [sdf_pkg::ValueW-1:0] b);
    return b[30:0] > 31'h7F800000;
  endfunction

  function automatic bit same_float(logic [sdf_pkg::ValueW-1:0] a,
                                    logic [sdf_pkg::ValueW-1:0] b);
    if (nan_pattern(a) || nan_pattern(b)) return 0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1;
    return a == b;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic predict_filter(sdf_tb_pkg::in_item_t it);
    sdf_tb_pkg::out_item_t r;
    bit hit;
    hit = 0;
    for (int i = 0; i < seen_cnt; i++)
      if (same_float(seen_vals[i], it.value_bits)) hit = 1;
    r = '0;
    r.value_echo = it.value_bits;
    r.last_out = it.last_item;
    if (hit) begin
      if (dup_cnt < 16'hFFFF) dup_cnt++;
    end else if (seen_cnt < sdf_pkg::StoreDepth) begin
      seen_vals[seen_cnt] = it.value_bits;
      seen_cnt++;
      r.is_new = 1;
    end else begin
      r.overflow = 1;
    end
    r.distinct_count = seen_cnt[sdf_pkg::DistW-1:0];
    r.removed_count = dup_cnt[sdf_pkg::RemW-1:0];
    expected_q.push_back(r);
    // close the set
    if (it.last_item) begin
      seen_cnt = 0;
      dup_cnt = 0;
    end
  endtask

  task automatic compare_result(sdf_tb_pkg::out_item_t got);
    sdf_tb_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result, value", got.value_echo, 0);
      return;
    end
    want = expected_q.pop_front();
    if (got.value_echo !== want.value_echo)
      report("value_echo", got.value_echo, want.value_echo);
    if (got.is_new !== want.is_new) report("is_new", got.is_new, want.is_new);
    if (got.distinct_count !== want.distinct_count)
      report("distinct_count", got.distinct_count, want.distinct_count);
    if (got.removed_count !== want.removed_count)
      report("removed_count", got.removed_count, want.removed_count);
    if (got.overflow !== want.overflow) report("overflow", got.overflow, want.overflow);
    if (got.last_out !== want.last_out) report("last_out", got.last_out, want.last_out);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      seen_cnt = 0;
      dup_cnt = 0;
    end else begin
      if (in_valid && in_ready) predict_filter(in_data);
      if (out_valid && out_ready) compare_result(out_data);
    end
  end

  assign pending = expected_q.size();
endmodule

@@ dv/tb.sv @@
// Testbench top for the stream distinct filter: drives directed and random
// sets with random idling and gives the verdict.
// Depends on sdf_pkg, sdf_tb_pkg, sdf_stream_if and distinct_checker.
module tb;
  localparam int SettleCycles = sdf_pkg::StoreDepth + 20;
  localparam int StallLimit = 4000;
  localparam int LongHold = 300;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent;
  int   src_idle_pct;
  int   snk_idle_pct;
  bit   hold_req;
  int   hold_left;
  int   quiet_cycles;

  sdf_stream_if #(.payload_t(sdf_tb_pkg::in_item_t))  in_if(clk);
  sdf_stream_if #(.payload_t(sdf_tb_pkg::out_item_t)) out_if(clk);

  stream_distinct_filter_top dut (
    .clk(clk),
    .rst(rst),
    .in_s(in_if.sink),
    .out_s(out_if.source)
  );

  distinct_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_data(in_if.data),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result receiver with random stalls and repeated long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 0;
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= LongHold;
      out_if.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= (hold_left == 1);
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(logic [31:0] v, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 0;
      @(posedge clk);
    end
    in_if.valid <= 1;
    in_if.data <= '{value_bits: v, last_item: last};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
    if (sent == 500) hold_req = 1;
    if (sent == 510) hold_req = 0;
  endtask

  task automatic drain_results();
    in_if.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {1'($urandom_range(1)), 8'hFF, 22'h0, 1'b0} | $urandom_range(1, 4);
      3: return 32'h7F80_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_set();
    logic [31:0] pool[6];
    int len;
    bit wide;
    wide = ($urandom_range(9) < 2);
    len = wide ? $urandom_range(64, 80) : $urandom_range(1, 24);
    foreach (pool[i]) pool[i] = pick_value();
    for (int i = 0; i < len; i++) begin
      logic [31:0] v;
      // wide sets are mostly fresh values to fill the store
      if (wide) v = ($urandom_range(9) < 8) ? $urandom : pool[$urandom_range(5)];
      else v = ($urandom_range(9) < 7) ? pool[$urandom_range(5)] : $urandom;
      send_item(v, i == len - 1);
    end
  endtask

  initial begin
    logic [31:0] directed[14] = '{
      32'h3F80_0000, 32'h8000_0000, 32'h0000_0000, 32'h7F80_0000,
      32'hFF80_0000, 32'h7FC0_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
      32'h7F80_0001, 32'h0000_0001, 32'h3F80_0000, 32'h7F7F_FFFF,
      32'hFF80_0000, 32'h8000_0000};
    rst <= 1;
    sent = 0;
    hold_req = 0;
    src_idle_pct = 14;
    snk_idle_pct = 55;
    in_if.valid <= 0;
    in_if.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i], i == 13);
    send_item(32'h3F80_0000, 1);
    send_item(32'h3F80_0000, 1);
    drain_results();

    while (sent < 1600) begin
      if (sent > 533 && sent < 1066) begin
        src_idle_pct = 55;
        snk_idle_pct = 14;
      end else if (sent >= 1066) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      random_set();
      if (sent > 800 && sent < 830) drain_results();
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/sdf_pkg.sv
sv/sdf_stream_if.sv
sv/sdf_cell.sv
sv/stream_distinct_filter_top.sv
dv/sdf_tb_pkg.sv
dv/distinct_checker.sv
dv/tb.sv
